/* design/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PLCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("plcs assertion failed");

// Check a property on every clock edge, reset included.
`define PLCS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("plcs assertion failed");

`endif

/* design/plcs_pkg.sv */
package plcs_pkg;

  localparam int PIX_W   = 8;
  localparam int SLOPE_W = 16;
  localparam int OFFS_W  = 18;
  localparam int PROD_W  = SLOPE_W + PIX_W + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

  localparam logic [2:0] REG_LOW_THR  = 3'd0;
  localparam logic [2:0] REG_HIGH_THR = 3'd1;
  localparam logic [2:0] REG_SLOPE_LO = 3'd2;
  localparam logic [2:0] REG_OFFS_LO  = 3'd3;
  localparam logic [2:0] REG_SLOPE_MD = 3'd4;
  localparam logic [2:0] REG_OFFS_MD  = 3'd5;
  localparam logic [2:0] REG_SLOPE_HI = 3'd6;
  localparam logic [2:0] REG_OFFS_HI  = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } plcs_pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
  } plcs_pix_out_t;

  typedef struct packed {
    logic [PIX_W-1:0]          low_threshold;
    logic [PIX_W-1:0]          high_threshold;
    logic signed [SLOPE_W-1:0] slope_low;
    logic signed [OFFS_W-1:0]  offset_low;
    logic signed [SLOPE_W-1:0] slope_mid;
    logic signed [OFFS_W-1:0]  offset_mid;
    logic signed [SLOPE_W-1:0] slope_high;
    logic signed [OFFS_W-1:0]  offset_high;
  } plcs_cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } plcs_adv_t;

endpackage

/* design/piecewise_linear_contrast_stretch.sv */
// Maps each 8-bit channel of an RGB pixel through one shared three-segment
// transfer function y = slope * v + offset (segment three above high_threshold,
// segment two from low_threshold up, segment one below), keeps the integer part
// and clamps to 0..255. Takes one pixel per clock unless in_stall is high; each
// accepted pixel passes through the four-stage lane (segment select, multiply,
// offset add, clamp). Stages fill gaps when the output stalls, so up to four
// pixels are held in flight. Program the APB registers only while no pixel is
// in flight.
module piecewise_linear_contrast_stretch
  import plcs_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  plcs_pix_in_t      in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output plcs_pix_out_t     out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  plcs_cfg_t  cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  plcs_adv_t adv;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold  <= 8'd0;
      cfg_r.high_threshold <= 8'd255;
      cfg_r.slope_low      <= 16'sd256;
      cfg_r.offset_low     <= 18'sd0;
      cfg_r.slope_mid      <= 16'sd256;
      cfg_r.offset_mid     <= 18'sd0;
      cfg_r.slope_high     <= 16'sd256;
      cfg_r.offset_high    <= 18'sd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOW_THR:  cfg_r.low_threshold  <= pwdata[PIX_W-1:0];
        REG_HIGH_THR: cfg_r.high_threshold <= pwdata[PIX_W-1:0];
        REG_SLOPE_LO: cfg_r.slope_low      <= pwdata[SLOPE_W-1:0];
        REG_OFFS_LO:  cfg_r.offset_low     <= pwdata[OFFS_W-1:0];
        REG_SLOPE_MD: cfg_r.slope_mid      <= pwdata[SLOPE_W-1:0];
        REG_OFFS_MD:  cfg_r.offset_mid     <= pwdata[OFFS_W-1:0];
        REG_SLOPE_HI: cfg_r.slope_high     <= pwdata[SLOPE_W-1:0];
        REG_OFFS_HI:  cfg_r.offset_high    <= pwdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOW_THR:  prdata = DATA_W'(cfg_r.low_threshold);
      REG_HIGH_THR: prdata = DATA_W'(cfg_r.high_threshold);
      REG_SLOPE_LO: prdata = DATA_W'(unsigned'(cfg_r.slope_low));
      REG_OFFS_LO:  prdata = DATA_W'(unsigned'(cfg_r.offset_low));
      REG_SLOPE_MD: prdata = DATA_W'(unsigned'(cfg_r.slope_mid));
      REG_OFFS_MD:  prdata = DATA_W'(unsigned'(cfg_r.offset_mid));
      REG_SLOPE_HI: prdata = DATA_W'(unsigned'(cfg_r.slope_high));
      REG_OFFS_HI:  prdata = DATA_W'(unsigned'(cfg_r.offset_high));
      default:      prdata = '0;
    endcase
  end

  // advance a stage when it is empty or the stage after it moves
  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign adv.s1 = in_valid && rdy1;
  assign adv.s2 = v1_r && rdy2;
  assign adv.s3 = v2_r && rdy3;
  assign adv.s4 = v3_r && rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = v4_r;

  plcs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
    .clk (clk),
    .adv (adv),
    .cfg (cfg_r),
    .pix (in_data.red_in),
    .res (out_data.red_out)
  );

  plcs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
    .clk (clk),
    .adv (adv),
    .cfg (cfg_r),
    .pix (in_data.green_in),
    .res (out_data.green_out)
  );

  plcs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
    .clk (clk),
    .adv (adv),
    .cfg (cfg_r),
    .pix (in_data.blue_in),
    .res (out_data.blue_out)
  );

endmodule

/* design/plcs_lane.sv */
module plcs_lane
  import plcs_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  plcs_adv_t        adv,
  input  plcs_cfg_t        cfg,
  input  logic [PIX_W-1:0] pix,
  output logic [PIX_W-1:0] res
);

  logic [PIX_W-1:0]          v1_r;
  logic signed [SLOPE_W-1:0] slope1_r, slope1_nxt;
  logic signed [OFFS_W-1:0]  off1_r, off1_nxt;
  logic signed [PROD_W-1:0]  prod2_r, prod2_nxt;
  logic signed [OFFS_W-1:0]  off2_r;
  logic signed [ACC_W-1:0]   acc3_r, acc3_nxt;
  logic [PIX_W-1:0]          res4_r, res4_nxt;

  always_comb begin
    if (pix > cfg.high_threshold) begin
      slope1_nxt = cfg.slope_high;
      off1_nxt   = cfg.offset_high;
    end else if (pix >= cfg.low_threshold) begin
      slope1_nxt = cfg.slope_mid;
      off1_nxt   = cfg.offset_mid;
    end else begin
      slope1_nxt = cfg.slope_low;
      off1_nxt   = cfg.offset_low;
    end
  end

  assign prod2_nxt = slope1_r * $signed({1'b0, v1_r});
  assign acc3_nxt  = ACC_W'(prod2_r) + ACC_W'(off2_r);

  always_comb begin
    if (acc3_r[ACC_W-1]) begin
      res4_nxt = PIX_MIN;
    end else if (|acc3_r[ACC_W-2:FRAC_BITS+PIX_W]) begin
      res4_nxt = PIX_MAX;
    end else begin
      res4_nxt = acc3_r[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      v1_r     <= pix;
      slope1_r <= slope1_nxt;
      off1_r   <= off1_nxt;
    end
    if (adv.s2) begin
      prod2_r <= prod2_nxt;
      off2_r  <= off1_r;
    end
    if (adv.s3) begin
      acc3_r <= acc3_nxt;
    end
    if (adv.s4) begin
      res4_r <= res4_nxt;
    end
  end

  assign res = res4_r;

endmodule

/* design/plcs_checker.sv */
`include "assert_macros.svh"

module plcs_checker
  import plcs_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input plcs_pix_out_t out_data
);

  `PLCS_ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid)
  `PLCS_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> out_valid && out_stall)
  `PLCS_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data))
  `PLCS_ASSERT(a_out_drop_on_take, clk, rst_n, $fell(out_valid) |-> $past(!out_stall))

endmodule

bind piecewise_linear_contrast_stretch plcs_checker u_plcs_checker (.*);
